/* hw/rtl/rhkt_pkg.sv */
// shared types, codes and constants of the reference-counted key table
package rhkt_pkg;

  localparam int BUCKET_COUNT_DEF = 1024;
  localparam int SLOT_COUNT_DEF   = 512;
  localparam int HOLDER_BITS_DEF  = 16;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 9;
  localparam int STATUS_W = 4;
  localparam int HANDLE_W = 9;
  localparam int COUNT_W  = 16;
  localparam int ENTRY_W  = 10;

  localparam int LIVE_WORD = 32;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int MIX_S0 = 30;
  localparam int MIX_S1 = 27;
  localparam int MIX_S2 = 31;

  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUBLISH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 4'd0,
    ST_MISS      = 4'd1,
    ST_INSERTED  = 4'd2,
    ST_DUPLICATE = 4'd3,
    ST_FULL      = 4'd4,
    ST_OVERFLOW  = 4'd5,
    ST_HELD      = 4'd6,
    ST_REMOVED   = 4'd7,
    ST_BAD       = 4'd8
  } status_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_HASH_KEY,
    CMD_HASH_ENT,
    CMD_HEAD_READ,
    CMD_LOAD_CUR_HEAD,
    CMD_ENT_READ_CUR,
    CMD_STEP,
    CMD_RES_MISS,
    CMD_RES_OVF,
    CMD_ACQ_INC,
    CMD_RES_DUP,
    CMD_LIVE_READ,
    CMD_WORD_NEXT,
    CMD_PUB_INSERT,
    CMD_RES_FULL,
    CMD_RES_BAD,
    CMD_REL_READ,
    CMD_REL_DEC,
    CMD_UNL_HEAD,
    CMD_UNL_PREV,
    CMD_REMOVE
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [KEY_W-1:0]  key;
    logic [SLOT_W-1:0]        slot;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [HANDLE_W-1:0]      handle;
    logic [COUNT_W-1:0]       holder_count;
    logic [ENTRY_W-1:0]       entry_count;
  } rsp_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic hash_done;
    logic head_v;
    logic head_is_slot;
    logic cur_v;
    logic key_eq;
    logic hold_max;
    logic hold_gt1;
    logic link_v;
    logic link_is_slot;
    logic word_free;
    logic word_last;
    logic slot_ok;
    logic slot_live;
    logic out_free;
    logic clr_last;
  } dp_status_t;

endpackage

/* hw/rtl/rhkt_hash.sv */
// iterative splitmix64 finalizer and bucket reduction
module rhkt_hash #(
  parameter int BUCKET_COUNT = rhkt_pkg::BUCKET_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [63:0]                         key,
  output logic                                done,
  output logic [$clog2(BUCKET_COUNT)-1:0]     bucket
);

  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int RW = BW + 1;
  localparam bit POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
  localparam int MB = 4;
  localparam int NSTEP = 64 / MB;
  localparam int MCW = $clog2(NSTEP);
  localparam logic [2:0] MUL_LAST = 3'd5;

  logic [63:0] x, acc, h, pp, sum, mixed, c;
  logic [31:0] a_op, b_op;
  logic [2:0]  cnt;
  logic [1:0]  k;
  logic        second, busy, mod_busy;
  logic [MCW-1:0] mcnt;
  logic [RW-1:0]  rem, rem_next;

  assign second = cnt >= 3'd3;
  assign k = second ? 2'(cnt - 3'd3) : 2'(cnt);
  assign c = second ? rhkt_pkg::MIX_C2 : rhkt_pkg::MIX_C1;

  always_comb begin
    unique case (k)
      2'd0: begin
        a_op = x[31:0];
        b_op = c[31:0];
      end
      2'd1: begin
        a_op = x[63:32];
        b_op = c[31:0];
      end
      default: begin
        a_op = x[31:0];
        b_op = c[63:32];
      end
    endcase
  end

  assign pp = a_op * b_op;
  assign sum = (k == 2'd0) ? pp : acc + {pp[31:0], 32'b0};
  assign mixed = second ? (sum ^ (sum >> rhkt_pkg::MIX_S2)) : (sum ^ (sum >> rhkt_pkg::MIX_S1));

  always_comb begin
    rem_next = rem;
    for (int i = 0; i < MB; i++) begin
      rem_next = {rem_next[RW-2:0], h[63-i]};
      if (rem_next >= RW'(BUCKET_COUNT)) rem_next = rem_next - RW'(BUCKET_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      mod_busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      mcnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          if (POW2) begin
            done <= 1'b1;
          end else begin
            mod_busy <= 1'b1;
            mcnt <= '0;
          end
        end
      end else if (mod_busy) begin
        mcnt <= mcnt + MCW'(1);
        if (mcnt == MCW'(NSTEP - 1)) begin
          mod_busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= key ^ (key >> rhkt_pkg::MIX_S0);
    end else if (busy) begin
      acc <= sum;
      if (k == 2'd2) x <= mixed;
      if (cnt == MUL_LAST) begin
        bucket <= BW'(mixed);
        h <= mixed;
        rem <= '0;
      end
    end else if (mod_busy) begin
      h <= h << MB;
      rem <= rem_next;
      if (mcnt == MCW'(NSTEP - 1)) bucket <= BW'(rem_next);
    end
  end

endmodule

/* hw/rtl/rhkt_dp.sv */
// datapath: chain heads, entry stores, live map, counters and result register
module rhkt_dp #(
  parameter int BUCKET_COUNT = rhkt_pkg::BUCKET_COUNT_DEF,
  parameter int SLOT_COUNT   = rhkt_pkg::SLOT_COUNT_DEF,
  parameter int HOLDER_BITS  = rhkt_pkg::HOLDER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rhkt_pkg::cmd_t        cmd,
  output rhkt_pkg::dp_status_t  st,
  input  rhkt_pkg::req_t        req,
  output rhkt_pkg::rsp_t        rsp,
  output logic                  rsp_valid,
  input  logic                  rsp_ready
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int HB = HOLDER_BITS;
  localparam int LW = rhkt_pkg::LIVE_WORD;
  localparam int LB = $clog2(LW);
  localparam int NWORDS = (SLOT_COUNT + LW - 1) / LW;
  localparam int WW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int CLR_N = (BUCKET_COUNT > NWORDS) ? BUCKET_COUNT : NWORDS;
  localparam int KW = $clog2(CLR_N);
  localparam int HW = rhkt_pkg::HANDLE_W;
  localparam int OW = rhkt_pkg::COUNT_W;
  localparam int EW = rhkt_pkg::ENTRY_W;

  rhkt_pkg::req_t item;
  rhkt_pkg::rsp_t res;
  logic           res_set;

  logic [63:0]    item_key;
  logic [SW-1:0]  rel_idx;
  logic [WW-1:0]  rel_word;
  logic [LB-1:0]  rel_bit;

  logic [BW-1:0]  bucket;
  logic           hash_done, hash_start;
  logic [63:0]    hash_key;

  logic [SW:0]    head_mem [BUCKET_COUNT];
  logic [63:0]    key_mem  [SLOT_COUNT];
  logic [HB-1:0]  hold_mem [SLOT_COUNT];
  logic [SW:0]    link_mem [SLOT_COUNT];
  logic [LW-1:0]  live_mem [NWORDS];

  logic [SW:0]    head_rd, link_rd, link_sv;
  logic [63:0]    key_rd;
  logic [HB-1:0]  hold_rd, hold_inc, hold_dec;
  logic [LW-1:0]  live_rd;

  logic [SW-1:0]  cur;
  logic           cur_v;
  logic [WW-1:0]  word_idx;
  logic [KW-1:0]  clr_idx;
  logic [CW-1:0]  live_total, live_inc, live_dec;

  logic [LW-1:0]  word_mask, free_vec;
  logic [LB-1:0]  free_bit;
  logic [SW-1:0]  ins_slot;

  logic           head_we, key_we, hold_we, link_we, live_we, ent_re, live_re;
  logic [BW-1:0]  head_wa;
  logic [SW:0]    head_wd, link_wd;
  logic [SW-1:0]  hold_wa, link_wa, ent_ra;
  logic [HB-1:0]  hold_wd;
  logic [WW-1:0]  live_wa, live_ra;
  logic [LW-1:0]  live_wd;

  assign item_key = item.key;
  assign rel_idx  = SW'(item.slot);
  assign rel_word = WW'(rel_idx >> LB);
  assign rel_bit  = LB'(rel_idx);
  assign hold_inc = hold_rd + HB'(1);
  assign hold_dec = hold_rd - HB'(1);
  assign live_inc = live_total + CW'(1);
  assign live_dec = (live_total != '0) ? live_total - CW'(1) : live_total;

  assign hash_start = (cmd == rhkt_pkg::CMD_HASH_KEY) || (cmd == rhkt_pkg::CMD_HASH_ENT);
  assign hash_key   = (cmd == rhkt_pkg::CMD_HASH_ENT) ? key_rd : item_key;

  rhkt_hash #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key    (hash_key),
    .done   (hash_done),
    .bucket (bucket)
  );

  always_comb begin
    for (int b = 0; b < LW; b++) begin
      word_mask[b] = (int'(word_idx) * LW + b) < SLOT_COUNT;
    end
  end

  assign free_vec = ~live_rd & word_mask;

  always_comb begin
    free_bit = '0;
    for (int b = LW - 1; b >= 0; b--) begin
      if (free_vec[b]) free_bit = LB'(b);
    end
  end

  assign ins_slot = SW'({word_idx, free_bit});

  always_comb begin
    st.func         = item.func;
    st.hash_done    = hash_done;
    st.head_v       = head_rd[SW];
    st.head_is_slot = head_rd[SW-1:0] == rel_idx;
    st.cur_v        = cur_v;
    st.key_eq       = key_rd == item_key;
    st.hold_max     = hold_rd == {HB{1'b1}};
    st.hold_gt1     = hold_rd > HB'(1);
    st.link_v       = link_rd[SW];
    st.link_is_slot = link_rd[SW-1:0] == rel_idx;
    st.word_free    = |free_vec;
    st.word_last    = word_idx == WW'(NWORDS - 1);
    st.slot_ok      = 17'(item.slot) < 17'(SLOT_COUNT);
    st.slot_live    = live_rd[rel_bit];
    st.out_free     = !rsp_valid || rsp_ready;
    st.clr_last     = clr_idx == KW'(CLR_N - 1);
  end

  always_comb begin
    head_we = 1'b0;
    head_wa = bucket;
    head_wd = '0;
    key_we  = 1'b0;
    hold_we = 1'b0;
    hold_wa = cur;
    hold_wd = hold_inc;
    link_we = 1'b0;
    link_wa = cur;
    link_wd = link_sv;
    live_we = 1'b0;
    live_wa = word_idx;
    live_wd = live_rd;
    ent_re  = 1'b0;
    ent_ra  = cur;
    live_re = 1'b0;
    live_ra = word_idx;
    res_set = 1'b0;
    res.status       = rhkt_pkg::ST_MISS;
    res.handle       = '0;
    res.holder_count = '0;
    res.entry_count  = EW'(live_total);
    unique case (cmd)
      rhkt_pkg::CMD_CLEAR: begin
        head_we = 32'(clr_idx) < BUCKET_COUNT;
        head_wa = BW'(clr_idx);
        live_we = 32'(clr_idx) < NWORDS;
        live_wa = WW'(clr_idx);
        live_wd = '0;
      end
      rhkt_pkg::CMD_ENT_READ_CUR: ent_re = 1'b1;
      rhkt_pkg::CMD_LIVE_READ: live_re = 1'b1;
      rhkt_pkg::CMD_REL_READ: begin
        ent_re  = 1'b1;
        ent_ra  = rel_idx;
        live_re = 1'b1;
        live_ra = rel_word;
      end
      rhkt_pkg::CMD_RES_MISS: res_set = 1'b1;
      rhkt_pkg::CMD_RES_OVF, rhkt_pkg::CMD_RES_DUP: begin
        res_set = 1'b1;
        res.status = (cmd == rhkt_pkg::CMD_RES_OVF) ? rhkt_pkg::ST_OVERFLOW
                                                   : rhkt_pkg::ST_DUPLICATE;
        res.handle = HW'(cur);
        res.holder_count = OW'(hold_rd);
      end
      rhkt_pkg::CMD_ACQ_INC: begin
        hold_we = 1'b1;
        res_set = 1'b1;
        res.status = rhkt_pkg::ST_HIT;
        res.handle = HW'(cur);
        res.holder_count = OW'(hold_inc);
      end
      rhkt_pkg::CMD_PUB_INSERT: begin
        key_we  = 1'b1;
        hold_we = 1'b1;
        hold_wa = ins_slot;
        hold_wd = HB'(1);
        link_we = 1'b1;
        link_wa = ins_slot;
        link_wd = head_rd;
        head_we = 1'b1;
        head_wd = {1'b1, ins_slot};
        live_we = 1'b1;
        live_wd = live_rd | (LW'(1) << free_bit);
        res_set = 1'b1;
        res.status = rhkt_pkg::ST_INSERTED;
        res.handle = HW'(ins_slot);
        res.holder_count = OW'(1);
        res.entry_count = EW'(live_inc);
      end
      rhkt_pkg::CMD_RES_FULL: begin
        res_set = 1'b1;
        res.status = rhkt_pkg::ST_FULL;
      end
      rhkt_pkg::CMD_RES_BAD: begin
        res_set = 1'b1;
        res.status = rhkt_pkg::ST_BAD;
        res.handle = HW'(item.slot);
      end
      rhkt_pkg::CMD_REL_DEC: begin
        hold_we = 1'b1;
        hold_wa = rel_idx;
        hold_wd = hold_dec;
        res_set = 1'b1;
        res.status = rhkt_pkg::ST_HELD;
        res.handle = HW'(rel_idx);
        res.holder_count = OW'(hold_dec);
      end
      rhkt_pkg::CMD_UNL_HEAD: begin
        head_we = 1'b1;
        head_wd = link_sv;
      end
      rhkt_pkg::CMD_UNL_PREV: link_we = 1'b1;
      rhkt_pkg::CMD_REMOVE: begin
        live_we = 1'b1;
        live_wa = rel_word;
        live_wd = live_rd & ~(LW'(1) << rel_bit);
        res_set = 1'b1;
        res.status = rhkt_pkg::ST_REMOVED;
        res.handle = HW'(rel_idx);
        res.entry_count = EW'(live_dec);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd == rhkt_pkg::CMD_HEAD_READ) head_rd <= head_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[ins_slot] <= item_key;
    if (ent_re) key_rd <= key_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (hold_we) hold_mem[hold_wa] <= hold_wd;
    if (ent_re) hold_rd <= hold_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (ent_re) link_rd <= link_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (live_we) live_mem[live_wa] <= live_wd;
    if (live_re) live_rd <= live_mem[live_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      live_total <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd == rhkt_pkg::CMD_CLEAR) clr_idx <= clr_idx + KW'(1);
      if (cmd == rhkt_pkg::CMD_PUB_INSERT) live_total <= live_inc;
      if (cmd == rhkt_pkg::CMD_REMOVE) live_total <= live_dec;
      if (res_set) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) rsp <= res;
    if (cmd == rhkt_pkg::CMD_LOAD) begin
      item <= req;
      word_idx <= '0;
    end
    if (cmd == rhkt_pkg::CMD_WORD_NEXT) word_idx <= word_idx + WW'(1);
    if (cmd == rhkt_pkg::CMD_LOAD_CUR_HEAD) begin
      cur <= head_rd[SW-1:0];
      cur_v <= head_rd[SW];
    end
    if (cmd == rhkt_pkg::CMD_STEP) begin
      cur <= link_rd[SW-1:0];
      cur_v <= link_rd[SW];
    end
    if (cmd == rhkt_pkg::CMD_HASH_ENT) link_sv <= link_rd;
  end

  a_res_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_set |-> (!rsp_valid || rsp_ready))
    else $error("result written over a pending transfer");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    32'(live_total) <= SLOT_COUNT)
    else $error("live entry count above pool size");

  a_remove_live: assert property (@(posedge clk) disable iff (rst)
    (cmd == rhkt_pkg::CMD_REMOVE) |-> live_rd[rel_bit])
    else $error("removing a slot that is not live");

endmodule

/* hw/rtl/rhkt_ctrl.sv */
// controller state machine sequencing lookup, insert and release
module rhkt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output rhkt_pkg::cmd_t        cmd,
  input  rhkt_pkg::dp_status_t  st
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_HASH_WAIT,
    S_HEAD_CHK,
    S_WALK,
    S_CMP,
    S_FREE_RD,
    S_FREE_CHK,
    S_REL,
    S_REL_CHK,
    S_UNL_HASH,
    S_UNL_HEAD_CHK,
    S_UNL_WALK,
    S_UNL_CMP,
    S_REMOVE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = rhkt_pkg::CMD_NOP;
    unique case (state)
      S_CLEAR: begin
        cmd = rhkt_pkg::CMD_CLEAR;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd = rhkt_pkg::CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (st.func == rhkt_pkg::FUNC_RELEASE) begin
          state_next = S_REL;
        end else if (st.func == rhkt_pkg::FUNC_ACQUIRE || st.func == rhkt_pkg::FUNC_PUBLISH) begin
          cmd = rhkt_pkg::CMD_HASH_KEY;
          state_next = S_HASH_WAIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_HASH_WAIT: begin
        if (st.hash_done) begin
          cmd = rhkt_pkg::CMD_HEAD_READ;
          state_next = S_HEAD_CHK;
        end
      end
      S_HEAD_CHK: begin
        cmd = rhkt_pkg::CMD_LOAD_CUR_HEAD;
        state_next = S_WALK;
      end
      S_WALK: begin
        priority if (st.cur_v) begin
          cmd = rhkt_pkg::CMD_ENT_READ_CUR;
          state_next = S_CMP;
        end else if (st.func == rhkt_pkg::FUNC_PUBLISH) begin
          state_next = S_FREE_RD;
        end else if (st.out_free) begin
          cmd = rhkt_pkg::CMD_RES_MISS;
          state_next = S_IDLE;
        end
      end
      S_CMP: begin
        priority if (!st.key_eq) begin
          cmd = rhkt_pkg::CMD_STEP;
          state_next = S_WALK;
        end else if (st.out_free) begin
          priority if (st.func == rhkt_pkg::FUNC_PUBLISH) cmd = rhkt_pkg::CMD_RES_DUP;
          else if (st.hold_max) cmd = rhkt_pkg::CMD_RES_OVF;
          else cmd = rhkt_pkg::CMD_ACQ_INC;
          state_next = S_IDLE;
        end
      end
      S_FREE_RD: begin
        cmd = rhkt_pkg::CMD_LIVE_READ;
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        priority if (!st.word_free && !st.word_last) begin
          cmd = rhkt_pkg::CMD_WORD_NEXT;
          state_next = S_FREE_RD;
        end else if (st.out_free) begin
          cmd = st.word_free ? rhkt_pkg::CMD_PUB_INSERT : rhkt_pkg::CMD_RES_FULL;
          state_next = S_IDLE;
        end
      end
      S_REL: begin
        priority if (st.slot_ok) begin
          cmd = rhkt_pkg::CMD_REL_READ;
          state_next = S_REL_CHK;
        end else if (st.out_free) begin
          cmd = rhkt_pkg::CMD_RES_BAD;
          state_next = S_IDLE;
        end
      end
      S_REL_CHK: begin
        priority if (st.slot_live && !st.hold_gt1) begin
          cmd = rhkt_pkg::CMD_HASH_ENT;
          state_next = S_UNL_HASH;
        end else if (st.out_free) begin
          cmd = st.slot_live ? rhkt_pkg::CMD_REL_DEC : rhkt_pkg::CMD_RES_BAD;
          state_next = S_IDLE;
        end
      end
      S_UNL_HASH: begin
        if (st.hash_done) begin
          cmd = rhkt_pkg::CMD_HEAD_READ;
          state_next = S_UNL_HEAD_CHK;
        end
      end
      S_UNL_HEAD_CHK: begin
        priority if (!st.head_v) begin
          state_next = S_REMOVE;
        end else if (st.head_is_slot) begin
          cmd = rhkt_pkg::CMD_UNL_HEAD;
          state_next = S_REMOVE;
        end else begin
          cmd = rhkt_pkg::CMD_LOAD_CUR_HEAD;
          state_next = S_UNL_WALK;
        end
      end
      S_UNL_WALK: begin
        cmd = rhkt_pkg::CMD_ENT_READ_CUR;
        state_next = S_UNL_CMP;
      end
      S_UNL_CMP: begin
        priority if (!st.link_v) begin
          state_next = S_REMOVE;
        end else if (st.link_is_slot) begin
          cmd = rhkt_pkg::CMD_UNL_PREV;
          state_next = S_REMOVE;
        end else begin
          cmd = rhkt_pkg::CMD_STEP;
          state_next = S_UNL_WALK;
        end
      end
      S_REMOVE: begin
        if (st.out_free) begin
          cmd = rhkt_pkg::CMD_REMOVE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      req_ready <= 1'b0;
    end else begin
      state <= state_next;
      req_ready <= state_next == S_IDLE;
    end
  end

endmodule

/* hw/rtl/refcounted_hash_key_table.sv */
// top level: reference-counted key table, one request at a time, one result per valid function code
// acquire hashes the key and walks the bucket chain, with a modulo pass in the hash when the bucket
//   count is not a power of two; a publish that misses then scans the live map in 32-slot words;
//   held release needs no hash; removal rehashes the entry key and walks its chain to unlink it
// next request: transfers once the current result sits in the output register
// reset: a clearing pass over the chain heads and the live map with ready low
module refcounted_hash_key_table #(
  parameter int BUCKET_COUNT = rhkt_pkg::BUCKET_COUNT_DEF,
  parameter int SLOT_COUNT   = rhkt_pkg::SLOT_COUNT_DEF,
  parameter int HOLDER_BITS  = rhkt_pkg::HOLDER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rhkt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rhkt_pkg::rsp_t rsp
);

  rhkt_pkg::cmd_t       cmd;
  rhkt_pkg::dp_status_t st;

  rhkt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .st        (st)
  );

  rhkt_dp #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .SLOT_COUNT   (SLOT_COUNT),
    .HOLDER_BITS  (HOLDER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule

/* dv/tb_top.sv */
// self-checking testbench for the reference-counted key table
`timescale 1ns / 100ps

module tb_top;

  localparam int NBUCKET = rhkt_pkg::BUCKET_COUNT_DEF;
  localparam int NSLOT   = rhkt_pkg::SLOT_COUNT_DEF;
  localparam int HOLD_MAX = (1 << rhkt_pkg::HOLDER_BITS_DEF) - 1;
  localparam logic [rhkt_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  rhkt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rhkt_pkg::rsp_t rsp;

  refcounted_hash_key_table u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the table
  int unsigned head_slot [NBUCKET];
  bit          head_v    [NBUCKET];
  logic [63:0] ent_key   [NSLOT];
  int unsigned ent_hold  [NSLOT];
  int unsigned ent_link  [NSLOT];
  bit          link_v    [NSLOT];
  bit          ent_live  [NSLOT];
  int unsigned live_total;

  rhkt_pkg::req_t pending_reqs[$];
  rhkt_pkg::rsp_t expected_rsps[$];
  int   errors = 0;
  bit   req_fire = 0;
  bit   no_idle = 0;
  int   req_gap = 0;
  int   rsp_gap = 0;
  logic [63:0] key_pool[48];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned bucket_of(logic [63:0] x);
    x = x ^ (x >> rhkt_pkg::MIX_S0);
    x = x * rhkt_pkg::MIX_C1;
    x = x ^ (x >> rhkt_pkg::MIX_S1);
    x = x * rhkt_pkg::MIX_C2;
    x = x ^ (x >> rhkt_pkg::MIX_S2);
    return int'(x % NBUCKET);
  endfunction

  function automatic bit find_key(int unsigned b, logic [63:0] k, output int unsigned s);
    bit v;
    int unsigned cur;
    v = head_v[b];
    cur = head_slot[b];
    s = 0;
    for (int n = 0; v && n < NSLOT; n++) begin
      if (cur >= NSLOT) return 0;
      if (ent_key[cur] == k) begin
        s = cur;
        return 1;
      end
      v = link_v[cur];
      cur = ent_link[cur];
    end
    return 0;
  endfunction

  function automatic void unlink_slot(int unsigned s);
    int unsigned b;
    int unsigned cur;
    b = bucket_of(ent_key[s]);
    if (head_v[b] && head_slot[b] == s) begin
      head_v[b] = link_v[s];
      head_slot[b] = ent_link[s];
      return;
    end
    if (!head_v[b]) return;
    cur = head_slot[b];
    for (int n = 0; n < NSLOT && cur < NSLOT; n++) begin
      if (!link_v[cur]) return;
      if (ent_link[cur] == s) begin
        link_v[cur] = link_v[s];
        ent_link[cur] = ent_link[s];
        return;
      end
      cur = ent_link[cur];
    end
  endfunction

  function automatic rhkt_pkg::rsp_t make_rsp(rhkt_pkg::status_t st, int unsigned h,
                                              int unsigned c);
    rhkt_pkg::rsp_t r;
    r.status = st;
    r.handle = h[rhkt_pkg::HANDLE_W-1:0];
    r.holder_count = c[rhkt_pkg::COUNT_W-1:0];
    r.entry_count = live_total[rhkt_pkg::ENTRY_W-1:0];
    return r;
  endfunction

  function automatic void apply_request(rhkt_pkg::req_t q);
    int unsigned b;
    int unsigned s;
    logic [63:0] k;
    k = q.key;
    case (q.func)
      rhkt_pkg::FUNC_ACQUIRE: begin
        b = bucket_of(k);
        if (!find_key(b, k, s))
          expected_rsps.push_back(make_rsp(rhkt_pkg::ST_MISS, 0, 0));
        else if (ent_hold[s] >= HOLD_MAX)
          expected_rsps.push_back(make_rsp(rhkt_pkg::ST_OVERFLOW, s, ent_hold[s]));
        else begin
          ent_hold[s]++;
          expected_rsps.push_back(make_rsp(rhkt_pkg::ST_HIT, s, ent_hold[s]));
        end
      end
      rhkt_pkg::FUNC_PUBLISH: begin
        b = bucket_of(k);
        if (find_key(b, k, s))
          expected_rsps.push_back(make_rsp(rhkt_pkg::ST_DUPLICATE, s, ent_hold[s]));
        else begin
          for (s = 0; s < NSLOT; s++)
            if (!ent_live[s]) break;
          if (s >= NSLOT)
            expected_rsps.push_back(make_rsp(rhkt_pkg::ST_FULL, 0, 0));
          else begin
            ent_live[s] = 1;
            ent_key[s] = k;
            ent_hold[s] = 1;
            ent_link[s] = head_slot[b];
            link_v[s] = head_v[b];
            head_slot[b] = s;
            head_v[b] = 1;
            live_total++;
            expected_rsps.push_back(make_rsp(rhkt_pkg::ST_INSERTED, s, 1));
          end
        end
      end
      rhkt_pkg::FUNC_RELEASE: begin
        s = q.slot;
        if (s >= NSLOT || !ent_live[s])
          expected_rsps.push_back(make_rsp(rhkt_pkg::ST_BAD, s, 0));
        else if (ent_hold[s] > 1) begin
          ent_hold[s]--;
          expected_rsps.push_back(make_rsp(rhkt_pkg::ST_HELD, s, ent_hold[s]));
        end else begin
          unlink_slot(s);
          ent_hold[s] = 0;
          ent_live[s] = 0;
          link_v[s] = 0;
          if (live_total > 0) live_total--;
          expected_rsps.push_back(make_rsp(rhkt_pkg::ST_REMOVED, s, 0));
        end
      end
      default: ;
    endcase
  endfunction

  // request transfer and prediction
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      apply_request(req);
      req_fire = 1;
    end
  end

  always @(negedge clk) begin
    logic v;
    v = req_valid;
    if (rst) begin
      v = 1'b0;
    end else if (req_valid && !req_fire) begin
      v = 1'b1;
    end else if (req_gap > 0) begin
      req_gap--;
      v = 1'b0;
    end else if (pending_reqs.size() > 0) begin
      req <= pending_reqs.pop_front();
      v = 1'b1;
      req_gap = no_idle ? 0 : pick_gap();
    end else begin
      v = 1'b0;
    end
    req_fire = 0;
    req_valid <= v;
  end

  // result side
  always @(negedge clk) begin
    if (no_idle || rsp_gap == 0) begin
      rsp_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) rsp_gap = pick_gap();
    end else begin
      rsp_gap--;
      rsp_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rhkt_pkg::rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
          errors++;
        end
        if (rsp.handle !== e.handle) begin
          $display("%0t: handle expected %0d actual %0d", $time, e.handle, rsp.handle);
          errors++;
        end
        if (rsp.holder_count !== e.holder_count) begin
          $display("%0t: holder_count expected %0d actual %0d", $time, e.holder_count,
                   rsp.holder_count);
          errors++;
        end
        if (rsp.entry_count !== e.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                   rsp.entry_count);
          errors++;
        end
      end
    end
  end

  task automatic send(logic [rhkt_pkg::FUNC_W-1:0] f, logic [63:0] k, int unsigned s);
    rhkt_pkg::req_t q;
    q.func = f;
    q.key = k;
    q.slot = s[rhkt_pkg::SLOT_W-1:0];
    pending_reqs.push_back(q);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int r;
    logic [63:0] k;
    for (int i = 0; i < NBUCKET; i++) begin
      head_v[i] = 0;
      head_slot[i] = 0;
    end
    for (int i = 0; i < NSLOT; i++) begin
      ent_live[i] = 0;
      link_v[i] = 0;
      ent_hold[i] = 0;
      ent_link[i] = 0;
      ent_key[i] = '0;
    end
    live_total = 0;
    key_pool[0] = 64'h0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = 64'h7fff_ffff_ffff_ffff;
    for (int i = 4; i < 48; i++) key_pool[i] = rand_key();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    send(rhkt_pkg::FUNC_ACQUIRE, 64'h0, 0);
    send(rhkt_pkg::FUNC_RELEASE, '0, 0);
    send(rhkt_pkg::FUNC_PUBLISH, 64'h0, 0);
    send(rhkt_pkg::FUNC_PUBLISH, '1, 0);
    send(rhkt_pkg::FUNC_PUBLISH, 64'h8000_0000_0000_0000, 0);
    send(rhkt_pkg::FUNC_PUBLISH, 64'h7fff_ffff_ffff_ffff, 0);
    send(rhkt_pkg::FUNC_PUBLISH, '1, 0);
    send(rhkt_pkg::FUNC_ACQUIRE, 64'h0, 0);
    send(rhkt_pkg::FUNC_ACQUIRE, 64'h0, 0);
    send(rhkt_pkg::FUNC_ACQUIRE, 64'h1234_5678_9abc_def0, 0);
    send(FUNC_NONE, '1, 511);
    send(rhkt_pkg::FUNC_RELEASE, '0, 0);
    send(rhkt_pkg::FUNC_RELEASE, '0, 511);
    send(rhkt_pkg::FUNC_RELEASE, '0, 1);
    send(rhkt_pkg::FUNC_RELEASE, '0, 1);
    send(rhkt_pkg::FUNC_ACQUIRE, '1, 0);
    send(rhkt_pkg::FUNC_RELEASE, '0, 0);
    send(rhkt_pkg::FUNC_RELEASE, '0, 0);
    send(rhkt_pkg::FUNC_PUBLISH, 64'h5555_aaaa_5555_aaaa, 0);
    send(rhkt_pkg::FUNC_ACQUIRE, 64'h7fff_ffff_ffff_ffff, 0);
    drain();

    // fill the pool past capacity
    for (int i = 0; i < 514; i++) send(rhkt_pkg::FUNC_PUBLISH, rand_key(), 0);
    send(rhkt_pkg::FUNC_PUBLISH, 64'h8000_0000_0000_0000, 0);
    send(rhkt_pkg::FUNC_ACQUIRE, 64'h8000_0000_0000_0000, 0);
    drain();

    // free scattered slots
    for (int i = 0; i < 40; i++)
      send(rhkt_pkg::FUNC_RELEASE, '0, $urandom_range(0, NSLOT - 1));
    drain();

    // random mix over a small key pool, the requests after a mid-run drain back to back
    for (int i = 0; i < 75; i++) begin
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? rand_key() : key_pool[$urandom_range(0, 47)];
      if (r < 35) send(rhkt_pkg::FUNC_ACQUIRE, k, 0);
      else if (r < 70) send(rhkt_pkg::FUNC_PUBLISH, k, 0);
      else if (r < 98)
        send(rhkt_pkg::FUNC_RELEASE, rand_key(),
             ($urandom_range(0, 7) == 0) ? $urandom_range(0, NSLOT - 1)
                                         : $urandom_range(0, 31));
      else send(FUNC_NONE, k, $urandom_range(0, NSLOT - 1));
      if (i == 40) begin
        drain();
        no_idle = 1;
      end
    end
    drain();
    no_idle = 0;

    if (errors == 0) begin
      $display("refcounted_hash_key_table test passed");
    end else begin
      $display("refcounted_hash_key_table test failed");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("refcounted_hash_key_table test failed");
    $finish;
  end

endmodule
